FILE: hdl/dir_pkg.sv
// Package for the dense ID renumbering block: sizes, opcodes, cell control bundle.
`timescale 1ns / 1ps
`default_nettype none
package dir_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int FUNC_W      = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR   = 3'd0,
        FN_COLLECT = 3'd1,
        FN_NUMBER  = 3'd2,
        FN_REMAP   = 3'd3,
        FN_READ    = 3'd4
    } func_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic             cmp;       // compare phase: latch lt / pick flags
        logic             rd;        // pick by position instead of by key
        logic             ins;       // insert: shift up and drop the new key in
        logic             num;       // renumber: value = position + 1
        logic [KEY_W-1:0] id;
        logic [IDX_W-1:0] rd_index;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] new_val;
    } cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/dir_cell.sv
// One table cell: holds a key and its dense number, compares and shifts up on insert.
`timescale 1ns / 1ps
`default_nettype none
module dir_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dir_pkg::cell_ctl_t         ctl,
    input  wire logic [dir_pkg::IDX_W-1:0]  cell_idx,
    input  wire logic [dir_pkg::KEY_W-1:0]  left_key,
    input  wire logic [dir_pkg::CNT_W-1:0]  left_val,
    input  wire logic                       left_lt,
    output logic      [dir_pkg::KEY_W-1:0]  key,
    output logic      [dir_pkg::CNT_W-1:0]  val,
    output logic                            lt,
    output logic                            pick,
    output logic      [dir_pkg::KEY_W-1:0]  pick_key,
    output logic      [dir_pkg::CNT_W-1:0]  pick_val
);

    logic [dir_pkg::KEY_W-1:0] key_reg;
    logic [dir_pkg::CNT_W-1:0] val_reg;
    logic                      lt_reg;
    logic                      pick_reg;
    logic                      valid;

    // Entry is live when its position is below the fill count.
    assign valid = ({1'b0, cell_idx} < ctl.count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg   <= 1'b0;
            pick_reg <= 1'b0;
        end
        else if (ctl.cmp)
        begin
            lt_reg   <= valid && (key_reg < ctl.id);
            pick_reg <= ctl.rd ? (valid && (cell_idx == ctl.rd_index))
                               : (valid && (key_reg == ctl.id));
        end
    end

    // Payload: no reset.
    always_ff @(posedge clk)
    begin
        if (ctl.ins && !lt_reg)
        begin
            if (left_lt)
            begin
                key_reg <= ctl.id;
                val_reg <= ctl.new_val;
            end
            else
            begin
                key_reg <= left_key;
                val_reg <= left_val;
            end
        end
        else if (ctl.num)
        begin
            val_reg <= {1'b0, cell_idx} + dir_pkg::CNT_W'(1);
        end
    end

    assign key      = key_reg;
    assign val      = val_reg;
    assign lt       = lt_reg;
    assign pick     = pick_reg;
    assign pick_key = pick_reg ? key_reg : '0;
    assign pick_val = pick_reg ? val_reg : '0;

endmodule
`default_nettype wire

FILE: hdl/dense_id_renumbering.sv
// Top level of the dense ID renumbering table: controller, cell chain, result register.
//
// Usage
//   Input stream (s_axis_*): one operation per transfer. tuser carries the
//   operation code (clear, collect, number, remap, read); tdata carries the
//   node ID and the sorted position used by read.
//   Output stream (m_axis_*): exactly one result transfer per input transfer,
//   in order: mapped ID, stored key and number (read), hit, overflow flag and
//   the entry count after the operation.
// Timing
//   Each operation passes a compare state, in which all 256 cells compare
//   their key against the ID in parallel, and then an update state, in which
//   the one-hot match flags are OR-reduced and the chain shifts up by one cell
//   to make room on insert. The result is registered; the next operation can
//   be taken while the current one is in its update state.
// Reset
//   rst_n clears the entry count, the sequencer and the output valid. Cell
//   contents are not reset; entries above the count are never observed.
// Backpressure
//   While m_axis_tready is low a finished result waits in the output
//   register; the next operation is still taken and compared, and holds in
//   its update cycle until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module dense_id_renumbering (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // node_id[31:0], entry_index[39:32]
    input  wire logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata    // mapped_id[8:0], entry_key[40:9],
                                             // entry_value[49:41], hit[50],
                                             // overflow[51], entry_count[60:52]
);

    localparam int N = dir_pkg::TABLE_DEPTH;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Held operation
    logic [dir_pkg::FUNC_W-1:0] func_reg;
    logic [dir_pkg::KEY_W-1:0]  id_reg;
    logic [dir_pkg::IDX_W-1:0]  idx_reg;
    logic [dir_pkg::CNT_W-1:0]  count_reg, count_next;

    logic                       out_valid_reg;
    logic [63:0]                out_data_reg;

    logic out_ok;
    logic in_xfer;
    logic upd_go;

    assign out_ok  = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) || ((state_reg == ST_UPD) && out_ok);
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign upd_go  = (state_reg == ST_UPD) && out_ok;

    // Cell chain wiring
    logic [dir_pkg::KEY_W-1:0] c_key      [N];
    logic [dir_pkg::CNT_W-1:0] c_val      [N];
    logic                      c_lt       [N];
    logic                      c_pick     [N];
    logic [dir_pkg::KEY_W-1:0] c_pick_key [N];
    logic [dir_pkg::CNT_W-1:0] c_pick_val [N];

    dir_pkg::cell_ctl_t ctl;

    // Match reduction (at most one cell picks)
    logic                      any_pick;
    logic [dir_pkg::KEY_W-1:0] sel_key;
    logic [dir_pkg::CNT_W-1:0] sel_val;

    always_comb
    begin
        any_pick = 1'b0;
        sel_key  = '0;
        sel_val  = '0;
        for (int i = 0; i < N; i++)
        begin
            any_pick = any_pick | c_pick[i];
            sel_key  = sel_key  | c_pick_key[i];
            sel_val  = sel_val  | c_pick_val[i];
        end
    end

    logic is_ins_op;
    logic full;
    logic do_ins;
    logic [dir_pkg::CNT_W-1:0] count_inc;

    assign is_ins_op = (func_reg == dir_pkg::FN_COLLECT) || (func_reg == dir_pkg::FN_REMAP);
    assign full      = (count_reg == dir_pkg::CNT_W'(N));
    assign do_ins    = is_ins_op && !any_pick && !full;
    assign count_inc = count_reg + dir_pkg::CNT_W'(1);

    always_comb
    begin
        ctl          = '0;
        ctl.cmp      = (state_reg == ST_CMP);
        ctl.rd       = (func_reg == dir_pkg::FN_READ);
        ctl.ins      = upd_go && do_ins;
        ctl.num      = upd_go && (func_reg == dir_pkg::FN_NUMBER);
        ctl.id       = id_reg;
        ctl.rd_index = idx_reg;
        ctl.count    = count_reg;
        ctl.new_val  = (func_reg == dir_pkg::FN_REMAP) ? count_inc : '0;
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            // Head cell sees a virtual smaller neighbor: lands the new key.
            dir_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .cell_idx (dir_pkg::IDX_W'(g)),
                .left_key ('0),
                .left_val ('0),
                .left_lt  (1'b1),
                .key      (c_key[g]),
                .val      (c_val[g]),
                .lt       (c_lt[g]),
                .pick     (c_pick[g]),
                .pick_key (c_pick_key[g]),
                .pick_val (c_pick_val[g])
            );
        end
        else
        begin : g_body
            dir_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .cell_idx (dir_pkg::IDX_W'(g)),
                .left_key (c_key[g-1]),
                .left_val (c_val[g-1]),
                .left_lt  (c_lt[g-1]),
                .key      (c_key[g]),
                .val      (c_val[g]),
                .lt       (c_lt[g]),
                .pick     (c_pick[g]),
                .pick_key (c_pick_key[g]),
                .pick_val (c_pick_val[g])
            );
        end
    end

    // Result fields
    logic [dir_pkg::CNT_W-1:0] r_mapped;
    logic [dir_pkg::KEY_W-1:0] r_key;
    logic [dir_pkg::CNT_W-1:0] r_val;
    logic                      r_hit;
    logic                      r_ovf;

    always_comb
    begin
        r_mapped   = '0;
        r_key      = '0;
        r_val      = '0;
        r_hit      = 1'b0;
        r_ovf      = 1'b0;
        count_next = count_reg;
        case (func_reg) inside
            dir_pkg::FN_CLEAR:
            begin
                count_next = '0;
            end
            dir_pkg::FN_COLLECT, dir_pkg::FN_REMAP:
            begin
                r_hit = any_pick;
                r_ovf = is_ins_op && !any_pick && full;
                if (do_ins)
                begin
                    count_next = count_inc;
                end
                if (func_reg == dir_pkg::FN_REMAP)
                begin
                    r_mapped = any_pick ? sel_val : (do_ins ? count_inc : '0);
                end
            end
            dir_pkg::FN_READ:
            begin
                r_key = sel_key;
                r_val = sel_val;
            end
            default:
            begin
                // number and unused codes: count unchanged, fields zero
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:
            begin
                if (out_ok)
                begin
                    state_next = in_xfer ? ST_CMP : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg <= s_axis_tuser;
            id_reg   <= s_axis_tdata[31:0];
            idx_reg  <= s_axis_tdata[39:32];
        end
        if (upd_go)
        begin
            out_data_reg <= {3'b000, count_next, r_ovf, r_hit, r_val, r_key, r_mapped};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

FILE: hdl/dir_checker.sv
// Port-level checks for the dense ID renumbering block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dir_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);

    logic [8:0] o_mapped;
    logic [8:0] o_count;
    logic       o_hit;
    logic       o_ovf;

    assign o_mapped = m_axis_tdata[8:0];
    assign o_hit    = m_axis_tdata[50];
    assign o_ovf    = m_axis_tdata[51];
    assign o_count  = m_axis_tdata[60:52];

    // Stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Count never passes the table depth.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> o_count <= 9'(dir_pkg::TABLE_DEPTH))
        else $error("entry count beyond depth");

    // Overflow only on a full table and never together with a hit.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && o_ovf |-> o_count == 9'(dir_pkg::TABLE_DEPTH) && !o_hit)
        else $error("overflow without a full table");

    // Dense numbers never exceed the count.
    a_mapped_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> o_mapped <= o_count)
        else $error("mapped id above entry count");

endmodule

bind dense_id_renumbering dir_checker u_dir_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for dense_id_renumbering: random and directed table operations checked against a local model.
`timescale 1ns / 1ps
module tb_top;

    localparam int CLK_PERIOD  = 8;
    localparam int TIMEOUT_NS  = 4_000_000;
    localparam int TAIL_CYCLES = 12;     // leave margin after the last result
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off

    // Opcodes the block treats as no-ops
    localparam logic [dir_pkg::FUNC_W-1:0] FN_SPARE_5 = 3'd5;
    localparam logic [dir_pkg::FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [dir_pkg::FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    // One result, fields in the order they sit in m_axis_tdata (high to low)
    typedef struct packed {
        logic [dir_pkg::CNT_W-1:0] count;
        logic                      ovf;
        logic                      hit;
        logic [dir_pkg::CNT_W-1:0] value;
        logic [dir_pkg::KEY_W-1:0] key;
        logic [dir_pkg::CNT_W-1:0] mapped;
    } rank_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // node_id[31:0], entry_index[39:32]
    logic [2:0]  s_axis_tuser = '0;     // func[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // mapped_id[8:0], entry_key[40:9], entry_value[49:41],
                                        // hit[50], overflow[51], entry_count[60:52]

    dense_id_renumbering DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Local copy of the sorted table
    logic [dir_pkg::KEY_W-1:0] tbl_keys [dir_pkg::TABLE_DEPTH];
    logic [dir_pkg::CNT_W-1:0] tbl_nums [dir_pkg::TABLE_DEPTH];
    int                        tbl_count = 0;

    rank_result_t              pending_results [$];
    logic [dir_pkg::KEY_W-1:0] id_pool [$];        // IDs recently used, to provoke hits

    int  err_count    = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  hits_seen    = 0;
    int  refused_seen = 0;
    bit  sender_gaps  = 1'b1;
    bit  rx_stalls    = 1'b1;
    int  hold_req     = 0;    // bumped by a test to start a hold-off
    int  hold_seen    = 0;
    int  hold_left    = 0;

    // Applies one operation to the local table and returns the expected result.
    function automatic rank_result_t apply_rank_op(logic [2:0] op,
                                                   logic [dir_pkg::KEY_W-1:0] id,
                                                   logic [7:0] idx);
        rank_result_t r;
        int           p;
        int           i;
        r = '0;
        case (op) inside
            dir_pkg::FN_CLEAR:
                tbl_count = 0;
            dir_pkg::FN_COLLECT, dir_pkg::FN_REMAP:
            begin
                p = 0;
                while (p < tbl_count && tbl_keys[p] < id)
                    p++;
                if (p < tbl_count && tbl_keys[p] == id)
                begin
                    r.hit = 1'b1;
                    if (op == dir_pkg::FN_REMAP)
                        r.mapped = tbl_nums[p];
                end
                else if (tbl_count >= dir_pkg::TABLE_DEPTH)
                    r.ovf = 1'b1;
                else
                begin
                    for (i = tbl_count; i > p; i--)
                    begin
                        tbl_keys[i] = tbl_keys[i-1];
                        tbl_nums[i] = tbl_nums[i-1];
                    end
                    tbl_keys[p] = id;
                    // collect leaves the number at zero until the next renumber
                    tbl_nums[p] = (op == dir_pkg::FN_REMAP) ?
                                  dir_pkg::CNT_W'(tbl_count + 1) : '0;
                    r.mapped    = tbl_nums[p];
                    tbl_count++;
                end
            end
            dir_pkg::FN_NUMBER:
                for (i = 0; i < tbl_count; i++)
                    tbl_nums[i] = dir_pkg::CNT_W'(i + 1);
            dir_pkg::FN_READ:
                if (idx < tbl_count)
                begin
                    r.key   = tbl_keys[idx];
                    r.value = tbl_nums[idx];
                end
            default: ;  // spare codes do nothing
        endcase
        r.count = dir_pkg::CNT_W'(tbl_count);
        return r;
    endfunction

    // Offers one operation and waits for its transfer; prediction happens on acceptance.
    task automatic send_op(logic [2:0] op, logic [dir_pkg::KEY_W-1:0] id, logic [7:0] idx);
        while (sender_gaps && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {idx, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(apply_rank_op(op, id, idx));
        items_sent++;
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mix of pool IDs (hits), extremes and fresh random IDs.
    function automatic logic [dir_pkg::KEY_W-1:0] pick_id();
        logic [dir_pkg::KEY_W-1:0] id;
        case ($urandom_range(9)) inside
            0:       id = $urandom_range(1) ? '1 : '0;
            [1:4]:
                id = (id_pool.size() != 0) ? id_pool[$urandom_range(id_pool.size() - 1)]
                                           : $urandom;
            5:       id = $urandom_range(15);
            default: id = $urandom;
        endcase
        id_pool.push_back(id);
        return id;
    endfunction

    // Receiver: random stalls, plus a long hold-off when a test asks for one
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !rx_stalls || ($urandom_range(99) >= 16);
    end

    // Result checker: every transfer against the oldest expectation
    always @(posedge clk)
    begin : result_check
        rank_result_t want;
        rank_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(rank_result_t)-1:0];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", m_axis_tdata);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                hits_seen    += want.hit;
                refused_seen += want.ovf;
                if (got.mapped !== want.mapped)
                begin
                    $error("mapped_id: expected %0d, got %0d", want.mapped, got.mapped);
                    err_count++;
                end
                if (got.key !== want.key)
                begin
                    $error("entry_key: expected %h, got %h", want.key, got.key);
                    err_count++;
                end
                if (got.value !== want.value)
                begin
                    $error("entry_value: expected %0d, got %0d", want.value, got.value);
                    err_count++;
                end
                if (got.hit !== want.hit)
                begin
                    $error("hit: expected %0b, got %0b", want.hit, got.hit);
                    err_count++;
                end
                if (got.ovf !== want.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", want.ovf, got.ovf);
                    err_count++;
                end
                if (got.count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, got.count);
                    err_count++;
                end
            end
        end
    end

    // Edges of every field, every opcode, spare codes, reads past the count
    task automatic test_directed();
        send_op(dir_pkg::FN_READ,    32'h0,         8'd0);      // read of an empty table
        send_op(dir_pkg::FN_REMAP,   32'd5,         8'd0);      // remap appends, number 1
        send_op(dir_pkg::FN_COLLECT, 32'h0,         8'hFF);     // lowest key, number 0
        send_op(dir_pkg::FN_COLLECT, 32'hFFFF_FFFF, 8'd0);      // highest key
        send_op(dir_pkg::FN_COLLECT, 32'h0,         8'd0);      // already present
        send_op(dir_pkg::FN_COLLECT, 32'h8000_0000, 8'd0);
        send_op(dir_pkg::FN_READ,    32'h0,         8'd0);
        send_op(dir_pkg::FN_READ,    32'h0,         8'd3);
        send_op(dir_pkg::FN_READ,    32'h0,         8'd4);      // one past the count
        send_op(dir_pkg::FN_READ,    32'h0,         8'hFF);     // far past the count
        send_op(dir_pkg::FN_NUMBER,  32'hFFFF_FFFF, 8'hFF);
        send_op(dir_pkg::FN_READ,    32'h0,         8'd0);
        send_op(dir_pkg::FN_READ,    32'h0,         8'd3);
        send_op(dir_pkg::FN_REMAP,   32'hFFFF_FFFF, 8'd0);      // hit, renumbered value
        send_op(dir_pkg::FN_REMAP,   32'd7,         8'd0);      // new, gets count + 1
        send_op(dir_pkg::FN_READ,    32'h0,         8'd2);
        send_op(FN_SPARE_5,          32'hFFFF_FFFF, 8'hFF);
        send_op(FN_SPARE_6,          32'h0,         8'd0);
        send_op(FN_SPARE_7,          32'hA5A5_5A5A, 8'h5A);
        send_op(dir_pkg::FN_CLEAR,   32'hFFFF_FFFF, 8'hFF);
        send_op(dir_pkg::FN_READ,    32'h0,         8'd0);      // nothing left after clear
        send_op(dir_pkg::FN_REMAP,   32'd0,         8'd0);
    endtask

    // Fill the table to one below its depth at full rate, then fill the last slot and hit the full-table cases.
    // Fill keys are even so any odd key is known to be absent.
    task automatic test_full_table();
        sender_gaps = 1'b0;
        rx_stalls   = 1'b0;
        send_op(dir_pkg::FN_CLEAR, 32'h0, 8'd0);
        while (tbl_count < dir_pkg::TABLE_DEPTH - 1)
            send_op(dir_pkg::FN_COLLECT, $urandom & ~32'd1, 8'($urandom));
        sender_gaps = 1'b1;
        rx_stalls   = 1'b1;
        send_op(dir_pkg::FN_NUMBER,  32'h0, 8'd0);
        send_op(dir_pkg::FN_REMAP,   $urandom | 32'd1, 8'd0);   // last slot, number 256
        send_op(dir_pkg::FN_COLLECT, $urandom | 32'd1, 8'd0);   // refused
        send_op(dir_pkg::FN_REMAP,   32'hFFFF_FFFF, 8'd0);      // refused, mapped 0
        send_op(dir_pkg::FN_REMAP,
                tbl_keys[$urandom_range(dir_pkg::TABLE_DEPTH - 1)], 8'd0);
        send_op(dir_pkg::FN_COLLECT, tbl_keys[0], 8'd0);        // hit on a full table
        send_op(dir_pkg::FN_NUMBER,  32'h0, 8'd0);
        send_op(dir_pkg::FN_READ,    32'h0, 8'd255);
        send_op(dir_pkg::FN_READ,    32'h0, 8'd0);
        send_op(dir_pkg::FN_READ,    32'h0, 8'($urandom));
        send_op(dir_pkg::FN_CLEAR,   32'h0, 8'd0);
    endtask

    // Sessions: clear, collect, mostly a renumber, then remaps, reads and collects; some noise between.
    task automatic test_random_sessions(int target);
        int n;
        while (items_sent < target)
        begin
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 4))
                    send_op(3'($urandom_range(7)), $urandom, 8'($urandom));
            else
            begin
                send_op(dir_pkg::FN_CLEAR, $urandom, 8'($urandom));
                id_pool.delete();
                n = ($urandom_range(7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 25);
                repeat (n)
                    send_op(dir_pkg::FN_COLLECT, pick_id(), 8'($urandom));
                if ($urandom_range(4) != 0)
                    send_op(dir_pkg::FN_NUMBER, $urandom, 8'($urandom));
                repeat ($urandom_range(1, 25))
                    case ($urandom_range(3))
                        0:       send_op(dir_pkg::FN_REMAP, pick_id(), 8'($urandom));
                        1:       send_op(dir_pkg::FN_READ, $urandom,
                                         8'($urandom_range(tbl_count)));
                        2:       send_op(dir_pkg::FN_READ, $urandom, 8'($urandom));
                        default: send_op(dir_pkg::FN_COLLECT, pick_id(), 8'($urandom));
                    endcase
            end
        end
    endtask

    // Long receiver hold-off while items keep coming, then a full drain, a renumber, reads and remaps.
    task automatic test_backpressure();
        hold_req++;
        repeat (40)
            send_op($urandom_range(1) ? dir_pkg::FN_COLLECT : dir_pkg::FN_REMAP,
                    pick_id(), 8'($urandom));
        drain_results();
        send_op(dir_pkg::FN_NUMBER, 32'h0, 8'd0);
        repeat (8)
            send_op(dir_pkg::FN_READ, $urandom, 8'($urandom_range(tbl_count)));
        repeat (6)
            send_op(dir_pkg::FN_REMAP, pick_id(), 8'($urandom));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random_sessions(720);
        test_backpressure();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Ran %0d operations, %0d results checked, incl. %0d hits and %0d refused inserts",
                 items_sent, results_seen, hits_seen, refused_seen);
        $display("Covered clear/collect/number/remap/read, spare codes, full table, stalls");
        if (err_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("FAIL");
        $finish;
    end

endmodule
